// File: design/lic_pkg.sv
// package with shared types and constants for the linear index to coordinates block
`timescale 1ns / 1ps
`default_nettype none
package lic_pkg;

  localparam int NUM_DIM_REGS = 4;
  localparam int SIZE_W       = 16;
  localparam int INDEX_W      = 32;
  localparam int COUNT_W      = 3;
  localparam int ADDR_W       = 5;
  localparam int REG_IDX_W    = 3;

  localparam logic [REG_IDX_W-1:0] REG_DIMS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIZE2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SIZE3 = 3'd4;

  typedef logic [NUM_DIM_REGS-1:0][SIZE_W-1:0] coord_vec_t;

  typedef struct packed {
    logic [COUNT_W-1:0] dims;
    coord_vec_t         size;
  } cfg_t;

endpackage
`default_nettype wire

// File: design/lic_pipe.sv
// pipelined restoring divider chain producing the coordinates
`timescale 1ns / 1ps
`default_nettype none
module lic_pipe #(
  parameter int MAX_DIMS = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire lic_pkg::cfg_t                    cfg_i,
  input  wire logic                             vld_i,
  input  wire logic [lic_pkg::INDEX_W-1:0]      idx_i,
  output logic                                  vld_o,
  output lic_pkg::coord_vec_t                   crd_o
);

  localparam int NDIM   = (MAX_DIMS < lic_pkg::NUM_DIM_REGS) ? MAX_DIMS
                                                             : lic_pkg::NUM_DIM_REGS;
  localparam int BPS    = 4;
  localparam int SPD    = lic_pkg::INDEX_W / BPS;
  localparam int STAGES = SPD * NDIM;

  logic [STAGES-1:0]                          vld_q;
  logic [STAGES-1:0][lic_pkg::INDEX_W-1:0]    quo_q;
  logic [STAGES-1:0][lic_pkg::SIZE_W-1:0]     rem_q;
  lic_pkg::coord_vec_t [STAGES-1:0]           crd_q;

  for (genvar j = 0; j < STAGES; j++) begin : g_st
    localparam int DIM  = NDIM - 1 - j / SPD;
    localparam int STEP = j % SPD;

    logic                          v_in;
    logic [lic_pkg::INDEX_W-1:0]   q_in;
    logic [lic_pkg::SIZE_W-1:0]    r_in;
    lic_pkg::coord_vec_t           c_in;
    logic [lic_pkg::SIZE_W-1:0]    dv;
    logic                          act;
    logic [lic_pkg::INDEX_W-1:0]   q_d;
    logic [lic_pkg::SIZE_W-1:0]    r_d;
    lic_pkg::coord_vec_t           c_d;

    if (j == 0) begin : g_first
      assign v_in = vld_i;
      assign q_in = idx_i;
      assign r_in = '0;
      assign c_in = '0;
    end else begin : g_next
      assign v_in = vld_q[j-1];
      assign q_in = quo_q[j-1];
      assign r_in = (STEP == 0) ? '0 : rem_q[j-1];
      assign c_in = crd_q[j-1];
    end

    assign dv  = (cfg_i.size[DIM] == '0) ? lic_pkg::SIZE_W'(1) : cfg_i.size[DIM];
    assign act = (lic_pkg::COUNT_W'(DIM) < cfg_i.dims);

    always_comb begin
      logic [lic_pkg::SIZE_W:0]    r;
      logic [lic_pkg::INDEX_W-1:0] q;
      r = {1'b0, r_in};
      q = q_in;
      if (act) begin
        for (int b = 0; b < BPS; b++) begin
          r = {r[lic_pkg::SIZE_W-1:0], q[lic_pkg::INDEX_W-1]};
          q = {q[lic_pkg::INDEX_W-2:0], 1'b0};
          if (r >= {1'b0, dv}) begin
            r    = r - {1'b0, dv};
            q[0] = 1'b1;
          end
        end
      end
      q_d = q;
      r_d = r[lic_pkg::SIZE_W-1:0];
      c_d = c_in;
      if (STEP == SPD - 1) begin
        c_d[DIM] = r[lic_pkg::SIZE_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[j] <= q_d;
      rem_q[j] <= r_d;
      crd_q[j] <= c_d;
    end
  end

  assign vld_o = vld_q[STAGES-1];
  assign crd_o = crd_q[STAGES-1];

endmodule
`default_nettype wire

// File: design/linear_index_to_coordinates_top.sv
// top level: configuration registers and coordinate pipeline
// start passes through the registered divider stages of lic_pipe to done_o
// throughput: one word per cycle, set by the 4-bit-per-stage divider chain
// busy stays low; the receiver cannot stall and the pipeline never holds
// reset: asynchronous active low, clears valid bits, sets dims_q and sizes to 1
`timescale 1ns / 1ps
`default_nettype none
module linear_index_to_coordinates_top #(
  parameter int MAX_DIMS = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lic_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [lic_pkg::INDEX_W-1:0]   linear_index_i,
  output logic                               done_o,
  output logic [lic_pkg::SIZE_W-1:0]         coord_0_o,
  output logic [lic_pkg::SIZE_W-1:0]         coord_1_o,
  output logic [lic_pkg::SIZE_W-1:0]         coord_2_o,
  output logic [lic_pkg::SIZE_W-1:0]         coord_3_o
);

  localparam int NDIM = (MAX_DIMS < lic_pkg::NUM_DIM_REGS) ? MAX_DIMS
                                                           : lic_pkg::NUM_DIM_REGS;

  logic [lic_pkg::COUNT_W-1:0]   dims_q;
  lic_pkg::coord_vec_t           size_q;
  logic [lic_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;
  lic_pkg::cfg_t                 cfg;
  lic_pkg::coord_vec_t           crd;

  assign reg_idx = paddr[lic_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= lic_pkg::COUNT_W'(1);
      size_q <= {lic_pkg::NUM_DIM_REGS{lic_pkg::SIZE_W'(1)}};
    end else if (wr_en) begin
      unique case (reg_idx)
        lic_pkg::REG_DIMS:  dims_q    <= pwdata[lic_pkg::COUNT_W-1:0];
        lic_pkg::REG_SIZE0: size_q[0] <= pwdata[lic_pkg::SIZE_W-1:0];
        lic_pkg::REG_SIZE1: size_q[1] <= pwdata[lic_pkg::SIZE_W-1:0];
        lic_pkg::REG_SIZE2: size_q[2] <= pwdata[lic_pkg::SIZE_W-1:0];
        lic_pkg::REG_SIZE3: size_q[3] <= pwdata[lic_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lic_pkg::REG_DIMS:  prdata = {29'd0, dims_q};
      lic_pkg::REG_SIZE0: prdata = {16'd0, size_q[0]};
      lic_pkg::REG_SIZE1: prdata = {16'd0, size_q[1]};
      lic_pkg::REG_SIZE2: prdata = {16'd0, size_q[2]};
      lic_pkg::REG_SIZE3: prdata = {16'd0, size_q[3]};
      default:            prdata = '0;
    endcase
  end

  // saturate the count to the built dimensions
  assign cfg.dims = (dims_q > lic_pkg::COUNT_W'(NDIM)) ? lic_pkg::COUNT_W'(NDIM) : dims_q;
  assign cfg.size = size_q;

  lic_pipe #(
    .MAX_DIMS(MAX_DIMS)
  ) u_pipe (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .vld_i (start & ~busy),
    .idx_i (linear_index_i),
    .vld_o (done_o),
    .crd_o (crd)
  );

  assign coord_0_o = crd[0];
  assign coord_1_o = crd[1];
  assign coord_2_o = crd[2];
  assign coord_3_o = crd[3];

endmodule
`default_nettype wire

// File: design/lic_chk.sv
// port-level checker for the linear index to coordinates block and its bind
`timescale 1ns / 1ps
`default_nettype none
module lic_chk #(
  parameter int MAX_DIMS = 4
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire logic pready
);

  localparam int NDIM = (MAX_DIMS < 4) ? MAX_DIMS : 4;
  localparam int LAT  = 8 * NDIM;

  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("accepted word did not complete");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("done without matching start");

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && pready)
    else $error("busy or pready wrong");

endmodule

bind linear_index_to_coordinates_top lic_chk #(.MAX_DIMS(MAX_DIMS)) u_lic_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .pready(pready)
);
`default_nettype wire

// File: verif/linear_index_to_coordinates_top_tb.sv
// testbench for linear_index_to_coordinates_top: table and random words against a predictor
`timescale 1ns / 1ps
`default_nettype none
module linear_index_to_coordinates_top_tb;

  typedef struct {
    logic [lic_pkg::SIZE_W-1:0] c0, c1, c2, c3;
  } coords_t;

  typedef struct {
    logic [lic_pkg::INDEX_W-1:0] idx;
    bit                          typed;
    coords_t                     res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [lic_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [lic_pkg::INDEX_W-1:0] linear_index_i = '0;
  logic done_o;
  logic [lic_pkg::SIZE_W-1:0] coord_0_o, coord_1_o, coord_2_o, coord_3_o;

  linear_index_to_coordinates_top u_dut (.*);

  logic [lic_pkg::COUNT_W-1:0] shadow_dims;
  logic [lic_pkg::SIZE_W-1:0]  shadow_size [lic_pkg::NUM_DIM_REGS];
  coords_t                     pending_coords [$];
  int                          errors = 0;
  int                          idle_pct = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic coords_t unravel(logic [lic_pkg::INDEX_W-1:0] idx);
    coords_t                     r;
    logic [lic_pkg::SIZE_W-1:0]  c [lic_pkg::NUM_DIM_REGS];
    logic [lic_pkg::INDEX_W-1:0] run;
    logic [lic_pkg::INDEX_W-1:0] sz;
    int                          n;
    run = idx;
    n = shadow_dims;
    if (n > lic_pkg::NUM_DIM_REGS) n = lic_pkg::NUM_DIM_REGS;
    for (int k = 0; k < lic_pkg::NUM_DIM_REGS; k++) c[k] = '0;
    for (int k = n - 1; k >= 0; k--) begin
      sz = (shadow_size[k] == 0) ? 1 : shadow_size[k];
      c[k] = lic_pkg::SIZE_W'(run % sz);
      run = run / sz;
    end
    r.c0 = c[0]; r.c1 = c[1]; r.c2 = c[2]; r.c3 = c[3];
    return r;
  endfunction

  task automatic reg_write(logic [lic_pkg::REG_IDX_W-1:0] ridx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = lic_pkg::ADDR_W'(ridx) << 2; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (ridx == lic_pkg::REG_DIMS) shadow_dims = val[lic_pkg::COUNT_W-1:0];
    else if (ridx <= lic_pkg::REG_SIZE3) shadow_size[ridx - 1] = val[lic_pkg::SIZE_W-1:0];
  endtask

  task automatic set_shape(logic [31:0] n, logic [31:0] s0, logic [31:0] s1,
                           logic [31:0] s2, logic [31:0] s3);
    reg_write(lic_pkg::REG_DIMS, n);
    reg_write(lic_pkg::REG_SIZE0, s0);
    reg_write(lic_pkg::REG_SIZE1, s1);
    reg_write(lic_pkg::REG_SIZE2, s2);
    reg_write(lic_pkg::REG_SIZE3, s3);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic drain_results();
    start = 1'b0;
    while (pending_coords.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // called at a falling edge, returns at a falling edge with start still high
  task automatic send_word(logic [lic_pkg::INDEX_W-1:0] idx, bit typed, coords_t res);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    linear_index_i = idx;
    do @(posedge clk_i); while (busy);
    pending_coords.push_back(typed ? res : unravel(idx));
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    coords_t want;
    if (rst_ni && done_o) begin
      if (pending_coords.size() == 0) begin
        $display("%0t: unexpected word %h %h %h %h", $time,
                 coord_0_o, coord_1_o, coord_2_o, coord_3_o);
        errors++;
      end else begin
        want = pending_coords.pop_front();
        if (want.c0 !== coord_0_o || want.c1 !== coord_1_o ||
            want.c2 !== coord_2_o || want.c3 !== coord_3_o) begin
          $display("%0t: expected %h %h %h %h actual %h %h %h %h", $time,
                   want.c0, want.c1, want.c2, want.c3,
                   coord_0_o, coord_1_o, coord_2_o, coord_3_o);
          errors++;
        end
      end
    end
  end

  coords_t   zc = '{0, 0, 0, 0};
  stim_row_t reset_rows [4];
  stim_row_t max_rows [6];

  initial begin
    shadow_dims = 1;
    for (int k = 0; k < lic_pkg::NUM_DIM_REGS; k++) shadow_size[k] = 1;
    reset_rows = '{'{32'h0, 1, zc}, '{32'hFFFF_FFFF, 1, zc},
                   '{32'h8000_0000, 1, zc}, '{32'h1234_5678, 1, zc}};
    max_rows = '{'{32'h0, 1, zc}, '{32'hFFFF_FFFF, 0, zc}, '{32'hFFFE, 0, zc},
                 '{32'hFFFF, 0, zc}, '{32'h5555_AAAA, 0, zc}, '{32'hAAAA_5555, 0, zc}};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset shape: everything collapses to zero
    foreach (reset_rows[i]) send_word(reset_rows[i].idx, reset_rows[i].typed, reset_rows[i].res);
    drain_results();

    // widest sizes, all dims
    set_shape(4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    foreach (max_rows[i]) send_word(max_rows[i].idx, max_rows[i].typed, max_rows[i].res);
    drain_results();

    // zero sizes, too many dims, unused dims, bad register index
    set_shape(7, 0, 16'hFFFF, 0, 3);
    reg_write(5, 32'h7);
    reg_write(7, 32'h0);
    send_word(32'hFFFF_FFFF, 0, zc);
    send_word(32'd10, 0, zc);
    drain_results();
    set_shape(0, 5, 5, 5, 5);
    send_word(32'hFFFF_FFFF, 1, zc);
    send_word(32'd123, 1, zc);
    drain_results();
    set_shape(2, 7, 16'hFFFF, 9, 9);
    send_word(32'hFFFF_FFFF, 0, zc);
    send_word(32'd70000, 0, zc);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 68;
        default: idle_pct = 17;
      endcase
      if (ph == 5) set_shape(1, 16'hFFFF, 1, 1, 1);
      else set_shape($urandom_range(4, 1) | ($urandom_range(1, 0) << 2),
                     $urandom_range(1, 0) ? $urandom_range(16, 1) : $urandom,
                     $urandom_range(1, 0) ? $urandom_range(16, 0) : $urandom,
                     $urandom_range(1, 0) ? $urandom_range(16, 1) : $urandom,
                     $urandom_range(1, 0) ? $urandom_range(16, 1) : $urandom);
      for (int i = 0; i < 250; i++) begin
        send_word($urandom_range(3, 0) == 0 ? $urandom_range(255, 0) : $urandom, 0, zc);
        if (i == 120 && ph == 1) drain_results();
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
